FILE: sv/rcf_pkg.sv
// Package for the RGB 3x3 convolution filter: payload structs, register
// indexes, reset values and the per-channel kernel arithmetic.
// No dependencies.
package rcf_pkg;

	localparam int RCF_MAX_WIDTH  = 2048;
	localparam int RCF_MAX_HEIGHT = 2048;
	localparam int RCF_SIZE_W     = 12;
	localparam int RCF_COEF_W     = 36;
	localparam int RCF_TAP_W      = 12;
	localparam int RCF_IDX_W      = 3;
	localparam int RCF_SUM_W      = 25;

	localparam logic [RCF_SIZE_W-1:0] RCF_WIDTH_RST  = RCF_SIZE_W'(640);
	localparam logic [RCF_SIZE_W-1:0] RCF_HEIGHT_RST = RCF_SIZE_W'(480);
	localparam logic [RCF_COEF_W-1:0] RCF_COEF_OUTER_RST = RCF_COEF_W'(64'd268566544);
	localparam logic [RCF_COEF_W-1:0] RCF_COEF_CENTER_RST = RCF_COEF_W'(64'd537133088);

	typedef enum logic [RCF_IDX_W-1:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_COEF_TOP_ROW    = 3'd2,
		REG_COEF_MIDDLE_ROW = 3'd3,
		REG_COEF_BOTTOM_ROW = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       run_last;
		logic       frame_end;
	} pix_out_t;

	// one vertical triple: [0] top, [1] middle, [2] bottom
	typedef logic [2:0][23:0] win_col_t;

	// nine taps of one channel, floored and clamped to 0..255
	function automatic logic [7:0] conv_channel(
		input logic [2:0][RCF_COEF_W-1:0] coef,
		input logic [2:0][2:0][7:0] smp
	);
		logic signed [RCF_SUM_W-1:0] acc;
		logic signed [RCF_TAP_W-1:0] tapv;
		logic signed [8:0] s;
		logic signed [RCF_TAP_W+8:0] prod;
		logic [7:0] res;
		acc = '0;
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				tapv = signed'(coef[j][RCF_TAP_W*i +: RCF_TAP_W]);
				s    = signed'({1'b0, smp[j][i]});
				prod = s * tapv;
				acc  = acc + RCF_SUM_W'(prod);
			end
		end
		if (acc < 0) begin
			res = 8'd0;
		end else if (acc[RCF_SUM_W-1:16] != '0) begin
			res = 8'd255;
		end else begin
			res = acc[15:8];
		end
		return res;
	endfunction

endpackage

FILE: sv/rcf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module rcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/rgb_3x3_convolution_filter.sv
// Top level of the RGB 3x3 convolution filter with edge replication.
// Depends on rcf_pkg and rcf_ram.
//
//   channel | direction | signals                       | transfer when
//   pix     | in        | pix_valid pix_stall pix_data  | pix_valid & !pix_stall
//   res     | out       | res_valid res_stall res_data  | res_valid & !res_stall
//   cfg     | in        | cfg_we cfg_index cfg_data     | cfg_we
//
// A pixel is registered into the input stage (line store read), then moves
// into the window, where the kernel unit issues each result it causes into
// the result register: none for the first row or for column 0, one for most
// pixels, two for the last column of a later row and for the last row past
// its first column, four for the final pixel. A first result passes the input stage, window and result register.
// Reset clears counters, valid flags and pending results; line stores are
// not cleared. A stalled result holds the result register and backs up input.
module rgb_3x3_convolution_filter
	import rcf_pkg::*;
#(
	parameter int MAX_WIDTH  = RCF_MAX_WIDTH,
	parameter int MAX_HEIGHT = RCF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_in_t               pix_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output pix_out_t              res_data,
	input  logic                  cfg_we,
	input  logic [RCF_IDX_W-1:0]  cfg_index,
	input  logic [RCF_COEF_W-1:0] cfg_data
);

	localparam int WCW  = $clog2(MAX_WIDTH);
	localparam int HCW  = $clog2(MAX_HEIGHT);
	localparam int WCMP = (RCF_SIZE_W > WCW + 1) ? RCF_SIZE_W : WCW + 1;
	localparam int HCMP = (RCF_SIZE_W > HCW + 1) ? RCF_SIZE_W : HCW + 1;

	logic [RCF_SIZE_W-1:0] width_q, height_q;
	logic [2:0][RCF_COEF_W-1:0] coef_q;

	logic [WCW-1:0] col_q;
	logic [HCW-1:0] row_q;
	logic [WCW-1:0] wm1;
	logic [HCW-1:0] hm1;
	logic [WCMP-1:0] w_ext;
	logic [HCMP-1:0] h_ext;
	logic last_col, last_row, accept;

	logic           valid_s1;
	pix_in_t        pix_s1;
	logic [WCW-1:0] col_s1;
	logic           row_zero_s1, last_col_s1, last_row_s1;
	logic [47:0]    rd_data;
	logic [23:0]    rd_older, rd_prev, older_wr;
	logic           s1_fire;

	win_col_t win_q [3];
	win_col_t col_new;
	logic [3:0] pend_q, pend_new, pend_rest;
	logic [1:0] k;
	logic       issue, out_free;
	logic [2:0][2:0][23:0] sel;
	logic [2:0][2:0][7:0] smp_r, smp_g, smp_b;

	pix_out_t res_q;
	logic     res_valid_q;

	function automatic logic [1:0] sel_idx(input logic [1:0] pos, input logic shift);
		logic [1:0] v;
		v = pos + {1'b0, shift};
		return (v > 2'd2) ? 2'd2 : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RCF_WIDTH_RST;
			height_q <= RCF_HEIGHT_RST;
			coef_q[0] <= RCF_COEF_OUTER_RST;
			coef_q[1] <= RCF_COEF_CENTER_RST;
			coef_q[2] <= RCF_COEF_OUTER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:     width_q   <= cfg_data[RCF_SIZE_W-1:0];
				REG_IMAGE_HEIGHT:    height_q  <= cfg_data[RCF_SIZE_W-1:0];
				REG_COEF_TOP_ROW:    coef_q[0] <= cfg_data;
				REG_COEF_MIDDLE_ROW: coef_q[1] <= cfg_data;
				REG_COEF_BOTTOM_ROW: coef_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_ext = WCMP'(width_q);
		h_ext = HCMP'(height_q);
		if (w_ext < WCMP'(2)) begin
			wm1 = WCW'(1);
		end else if (w_ext > WCMP'(MAX_WIDTH)) begin
			wm1 = WCW'(MAX_WIDTH - 1);
		end else begin
			wm1 = WCW'(w_ext - WCMP'(1));
		end
		if (h_ext < HCMP'(2)) begin
			hm1 = HCW'(1);
		end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
			hm1 = HCW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = HCW'(h_ext - HCMP'(1));
		end
		last_col = col_q >= wm1;
		last_row = row_q >= hm1;
	end

	assign accept    = pix_valid && !pix_stall;
	assign pix_stall = valid_s1 && !s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + HCW'(1);
			end else begin
				col_q <= col_q + WCW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pix_data;
			col_s1      <= col_q;
			row_zero_s1 <= row_q == '0;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	assign rd_older = rd_data[47:24];
	assign rd_prev  = rd_data[23:0];
	assign older_wr = row_zero_s1 ? pix_s1 : rd_prev;

	rcf_ram #(
		.WIDTH(48),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_fire),
		.waddr(col_s1),
		.wdata({older_wr, 24'(pix_s1)}),
		.re   (accept),
		.raddr(col_q),
		.rdata(rd_data)
	);

	always_comb begin
		if (pend_q[0]) begin
			k = 2'd0;
		end else if (pend_q[1]) begin
			k = 2'd1;
		end else if (pend_q[2]) begin
			k = 2'd2;
		end else begin
			k = 2'd3;
		end
		pend_rest = pend_q & ~(4'b0001 << k);
		out_free  = !res_valid_q || !res_stall;
		issue     = (pend_q != '0) && out_free;
		s1_fire   = valid_s1 && ((pend_q == '0) || (issue && (pend_rest == '0)));

		col_new[0] = rd_older;
		col_new[1] = rd_prev;
		col_new[2] = pix_s1;

		pend_new[0] = !row_zero_s1 && (col_s1 != '0);
		pend_new[1] = !row_zero_s1 && (col_s1 != '0) && last_row_s1;
		pend_new[2] = !row_zero_s1 && last_col_s1;
		pend_new[3] = !row_zero_s1 && last_col_s1 && last_row_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			if (col_s1 == '0) begin
				win_q[0] <= col_new;
				win_q[1] <= col_new;
				win_q[2] <= col_new;
			end else begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= col_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (s1_fire) begin
			pend_q <= pend_new;
		end else if (issue) begin
			pend_q <= pend_rest;
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				sel[j][i]   = win_q[sel_idx(2'(i), k[1])][sel_idx(2'(j), k[0])];
				smp_r[j][i] = sel[j][i][23:16];
				smp_g[j][i] = sel[j][i][15:8];
				smp_b[j][i] = sel[j][i][7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (issue) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			res_q.out_red   <= conv_channel(coef_q, smp_r);
			res_q.out_green <= conv_channel(coef_q, smp_g);
			res_q.out_blue  <= conv_channel(coef_q, smp_b);
			res_q.run_last  <= pend_rest == '0;
			res_q.frame_end <= k == 2'd3;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

FILE: sv/rcf_checker.sv
// Port-level checker for the RGB 3x3 convolution filter, bound to the top.
// Depends on rcf_pkg.
module rcf_checker
	import rcf_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     pix_valid,
	input logic     pix_stall,
	input logic     res_valid,
	input logic     res_stall,
	input pix_out_t res_data
);

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	// frame end closes the results of its pixel
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.frame_end |-> res_data.run_last)
		else $error("frame end without run last");

	// results of one pixel follow back to back
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_data.run_last |=> res_valid)
		else $error("gap inside a run of results");

	// input stalls only while a pixel is still in work
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> $past(pix_valid && !pix_stall) || $past(pix_stall))
		else $error("input stall without a pixel in work");

endmodule

bind rgb_3x3_convolution_filter rcf_checker u_rcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pix_valid(pix_valid),
	.pix_stall(pix_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);

FILE: tb/tb_rgb_3x3_convolution_filter.sv
`timescale 1ns / 1ps
// Testbench for rgb_3x3_convolution_filter. It sends pixel images through the valid/stall
// channels and checks each result against a built-in model of the edge-replicating kernel.
// It needs rcf_pkg and the filter RTL.
module tb_rgb_3x3_convolution_filter;
	import rcf_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int SETTLE       = 8;
	localparam int HOLD_CYCLES  = 120;
	localparam int RANDOM_ITEMS = 48;
	localparam int PRINT_LIMIT  = 30;

	typedef enum int {TAPS_RANDOM, TAPS_SMALL, TAPS_EXTREME} tap_style_t;

	class conv_scoreboard;
		logic [RCF_SIZE_W-1:0] width_reg;
		logic [RCF_SIZE_W-1:0] height_reg;
		logic [RCF_COEF_W-1:0] kernel_row [3];
		pix_in_t  older_row [RCF_MAX_WIDTH];
		pix_in_t  prev_row [RCF_MAX_WIDTH];
		pix_in_t  window [3][3];
		int       col_pos, row_pos;
		pix_out_t expected_px [$];
		int       errors, pixels, results;

		function new();
			width_reg     = 12'd640;
			height_reg    = 12'd480;
			kernel_row[0] = 36'd268566544;
			kernel_row[1] = 36'd537133088;
			kernel_row[2] = 36'd268566544;
			foreach (window[i, k]) window[i][k] = '0;
			col_pos = 0;
			row_pos = 0;
			errors  = 0;
			pixels  = 0;
			results = 0;
		endfunction

		function void write_reg(logic [RCF_IDX_W-1:0] idx, logic [RCF_COEF_W-1:0] value);
			case (idx)
				REG_IMAGE_WIDTH:     width_reg = value[RCF_SIZE_W-1:0];
				REG_IMAGE_HEIGHT:    height_reg = value[RCF_SIZE_W-1:0];
				REG_COEF_TOP_ROW:    kernel_row[0] = value;
				REG_COEF_MIDDLE_ROW: kernel_row[1] = value;
				REG_COEF_BOTTOM_ROW: kernel_row[2] = value;
				default: ;
			endcase
		endfunction

		// right/bottom replicate the outer window column/row into the missing neighbour
		function pix_out_t filtered(bit right, bit bottom, bit last_px);
			pix_out_t o;
			int sum, ci, rj;
			logic signed [RCF_TAP_W-1:0] coef;
			logic [7:0] chan [3];
			for (int ch = 0; ch < 3; ch++) begin
				sum = 0;
				for (int j = 0; j < 3; j++) begin
					for (int i = 0; i < 3; i++) begin
						ci   = (i + right > 2) ? 2 : i + right;
						rj   = (j + bottom > 2) ? 2 : j + bottom;
						coef = kernel_row[j][RCF_TAP_W*i +: RCF_TAP_W];
						sum += int'(window[ci][rj][8*(2-ch) +: 8]) * int'(coef);
					end
				end
				if (sum < 0) begin
					chan[ch] = 8'd0;
				end else if ((sum >>> 8) > 255) begin
					chan[ch] = 8'd255;
				end else begin
					chan[ch] = 8'(sum >>> 8);
				end
			end
			o.out_red   = chan[0];
			o.out_green = chan[1];
			o.out_blue  = chan[2];
			o.run_last  = 1'b0;
			o.frame_end = last_px;
			return o;
		endfunction

		function void note_pixel(pix_in_t px);
			int w, h, c, r;
			bit last_col, last_row;
			pix_in_t column [3];
			pix_out_t burst [$];
			pix_out_t tail;
			w = (width_reg < 2) ? 2 : (width_reg > RCF_MAX_WIDTH) ? RCF_MAX_WIDTH : width_reg;
			h = (height_reg < 2) ? 2 : (height_reg > RCF_MAX_HEIGHT) ? RCF_MAX_HEIGHT : height_reg;
			c = col_pos;
			r = row_pos;
			last_col = (c >= w - 1);
			last_row = (r >= h - 1);
			column[0] = older_row[c];
			column[1] = prev_row[c];
			column[2] = px;
			if (c == 0) begin
				foreach (window[i, k]) window[i][k] = column[k];
			end else begin
				window[0] = window[1];
				window[1] = window[2];
				window[2] = column;
			end
			older_row[c] = (r == 0) ? px : prev_row[c];
			prev_row[c]  = px;
			if (r >= 1) begin
				if (c >= 1) begin
					burst.push_back(filtered(1'b0, 1'b0, 1'b0));
					if (last_row) burst.push_back(filtered(1'b0, 1'b1, 1'b0));
				end
				if (last_col) begin
					burst.push_back(filtered(1'b1, 1'b0, 1'b0));
					if (last_row) burst.push_back(filtered(1'b1, 1'b1, 1'b1));
				end
			end
			if (burst.size() > 0) begin
				tail = burst.pop_back();
				tail.run_last = 1'b1;
				burst.push_back(tail);
			end
			foreach (burst[k]) expected_px.push_back(burst[k]);
			if (last_col) begin
				col_pos = 0;
				row_pos = last_row ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
			pixels++;
		endfunction

		function string describe(pix_out_t p);
			return $sformatf("rgb %0d/%0d/%0d last %b end %b",
				p.out_red, p.out_green, p.out_blue, p.run_last, p.frame_end);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
		endtask

		task check_result(pix_out_t got);
			pix_out_t want;
			results++;
			if (expected_px.size() == 0) begin
				report_mismatch($sformatf("result %0d unexpected: %s", results, describe(got)));
			end else begin
				want = expected_px.pop_front();
				if (got.out_red !== want.out_red || got.out_green !== want.out_green
						|| got.out_blue !== want.out_blue || got.run_last !== want.run_last
						|| got.frame_end !== want.frame_end)
					report_mismatch($sformatf("result %0d: got %s, expected %s",
						results, describe(got), describe(want)));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	pix_in_t               pix_data = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	pix_out_t              res_data;
	logic                  cfg_we = 1'b0;
	logic [RCF_IDX_W-1:0]  cfg_index = '0;
	logic [RCF_COEF_W-1:0] cfg_data = '0;

	conv_scoreboard sb = new();
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int images = 0;
	int settings = 0;

	rgb_3x3_convolution_filter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_data(pix_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_reg(cfg_index, cfg_data);
			if (pix_valid && pix_stall === 1'b0) sb.note_pixel(pix_data);
			if (res_valid === 1'b1 && !res_stall) sb.check_result(res_data);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && pix_stall === 1'b0) || (res_valid === 1'b1 && !res_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("rgb_3x3_convolution_filter regression: fail");
		$finish;
	end

	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				res_stall <= 1'b0;
			end else if (!steady && $urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end
		end
	end

	task automatic write_reg(logic [RCF_IDX_W-1:0] idx, logic [RCF_COEF_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// upper data bits are junk; only the low size bits count
	task automatic set_size(int w, int h);
		write_reg(REG_IMAGE_WIDTH, {24'($urandom), 12'(w)});
		write_reg(REG_IMAGE_HEIGHT, {24'($urandom), 12'(h)});
		settings++;
	endtask

	task automatic set_kernel(logic [RCF_COEF_W-1:0] top, logic [RCF_COEF_W-1:0] mid,
			logic [RCF_COEF_W-1:0] bot);
		write_reg(REG_COEF_TOP_ROW, top);
		write_reg(REG_COEF_MIDDLE_ROW, mid);
		write_reg(REG_COEF_BOTTOM_ROW, bot);
		if ($urandom_range(0, 3) == 0)
			write_reg(RCF_IDX_W'($urandom_range(int'(REG_COEF_BOTTOM_ROW) + 1,
				(1 << RCF_IDX_W) - 1)), RCF_COEF_W'({$urandom, $urandom}));
		settings++;
	endtask

	function automatic logic [RCF_COEF_W-1:0] rand_kernel_row(tap_style_t style);
		logic [RCF_COEF_W-1:0] row;
		row = RCF_COEF_W'({$urandom, $urandom});
		for (int i = 0; i < 3; i++) begin
			case (style)
				TAPS_SMALL: row[RCF_TAP_W*i +: RCF_TAP_W] = 12'($urandom_range(0, 160)) - 12'd64;
				TAPS_EXTREME: begin
					case ($urandom_range(0, 4))
						0: row[RCF_TAP_W*i +: RCF_TAP_W] = 12'h7FF;
						1: row[RCF_TAP_W*i +: RCF_TAP_W] = 12'h800;
						2: row[RCF_TAP_W*i +: RCF_TAP_W] = 12'h000;
						3: row[RCF_TAP_W*i +: RCF_TAP_W] = 12'h100;
						default: row[RCF_TAP_W*i +: RCF_TAP_W] = 12'hFFF;
					endcase
				end
				default: ;
			endcase
		end
		return row;
	endfunction

	function automatic pix_in_t rand_pixel();
		pix_in_t px;
		px = pix_in_t'($urandom);
		for (int ch = 0; ch < 3; ch++) begin
			case ($urandom_range(0, 7))
				0: px[8*ch +: 8] = 8'h00;
				1: px[8*ch +: 8] = 8'hFF;
				default: ;
			endcase
		end
		return px;
	endfunction

	task automatic send_pixel(pix_in_t px);
		if (!steady && $urandom_range(0, 5) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pix_data  <= px;
		do @(posedge clk); while (pix_stall !== 1'b0);
		@(negedge clk);
	endtask

	task automatic send_image(int count, int hold_at);
		for (int k = 0; k < count; k++) begin
			if (k == hold_at) hold_req = 1'b1;
			send_pixel(rand_pixel());
		end
		images++;
	endtask

	// hold off new stimulus until every pending result has been seen
	task automatic drain();
		pix_valid <= 1'b0;
		while (sb.expected_px.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		pix_in_t corner_px [9] = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF, 24'hFFFFFF,
			24'h000000, 24'h123456, 24'hFEDCBA, 24'h01FF80};
		pix_in_t tiny_px [4] = '{24'h010000, 24'hFF00FF, 24'h000000, 24'h0000FF};
		int rand_count, w, h, wv, hv;
		bit first;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset kernel (1/16 Gaussian) on a 3x3 image; writes to unused indexes are ignored
		set_size(3, 3);
		for (int k = int'(REG_COEF_BOTTOM_ROW) + 1; k < (1 << RCF_IDX_W); k++)
			write_reg(RCF_IDX_W'(k), '1);
		foreach (corner_px[k]) send_pixel(corner_px[k]);
		images++;
		drain();

		// sizes below two saturate to a 2x2 image; max positive taps saturate high
		set_size(1, 0);
		set_kernel(36'h7FF7FF7FF, 36'h7FF7FF7FF, 36'h7FF7FF7FF);
		foreach (tiny_px[k]) send_pixel(tiny_px[k]);
		images++;
		drain();

		set_kernel(36'h000000000, 36'hFFFFFFFFF, 36'h800800800);
		foreach (tiny_px[k]) send_pixel(~tiny_px[k]);
		images++;
		drain();

		set_size(2, 3);
		set_kernel(36'h000000000, 36'h000100000, 36'h000000000);
		send_image(6, -1);
		drain();

		rand_count = 0;
		first = 1'b1;
		while (rand_count < RANDOM_ITEMS) begin
			w  = first ? 8 : $urandom_range(2, 9);
			h  = first ? 5 : $urandom_range(2, 5);
			wv = (w == 2 && $urandom_range(0, 1)) ? $urandom_range(0, 1) : w;
			hv = (h == 2 && $urandom_range(0, 1)) ? $urandom_range(0, 1) : h;
			set_size(wv, hv);
			set_kernel(rand_kernel_row(tap_style_t'($urandom_range(0, 2))),
				rand_kernel_row(tap_style_t'($urandom_range(0, 2))),
				rand_kernel_row(tap_style_t'($urandom_range(0, 2))));
			send_image(w * h, first ? 4 : -1);
			drain();
			rand_count += w * h;
			first = 1'b0;
		end

		// shrink the size mid-image: counters past the new edge end the row and the image
		set_size(6, 4);
		send_image(14, -1);
		drain();
		set_size(3, 2);
		send_image(1, -1);
		drain();

		// oversized register values saturate; a later shrink closes the row or the image
		steady = 1'b1;
		set_size((1 << RCF_SIZE_W) - 1, 2);
		set_kernel(rand_kernel_row(TAPS_SMALL), rand_kernel_row(TAPS_SMALL),
			rand_kernel_row(TAPS_SMALL));
		send_image(10, -1);
		drain();
		set_size(3, 2);
		send_image(4, -1);
		drain();
		set_size(0, (1 << RCF_SIZE_W) - 1);
		set_kernel(rand_kernel_row(TAPS_RANDOM), rand_kernel_row(TAPS_SMALL),
			rand_kernel_row(TAPS_EXTREME));
		send_image(6, -1);
		drain();
		set_size(2, 2);
		send_image(2, -1);
		drain();

		$display("covered %0d pixels, %0d results, %0d images, %0d register settings,",
			sb.pixels, sb.results, images, settings);
		$display("with saturated sizes, mid-image resize and a long output hold");
		if (sb.errors == 0 && sb.expected_px.size() == 0)
			$display("rgb_3x3_convolution_filter regression: pass");
		else
			$display("rgb_3x3_convolution_filter regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
sv/rcf_pkg.sv
sv/rcf_ram.sv
sv/rgb_3x3_convolution_filter.sv
sv/rcf_checker.sv
tb/tb_rgb_3x3_convolution_filter.sv
